### sv/windowed_flow_event_store_defines.svh
// assertion macros for the windowed flow event store
// used by windowed_flow_event_store.sv, expects clk_i and rst_ni in scope
`ifndef WINDOWED_FLOW_EVENT_STORE_DEFINES_SVH
`define WINDOWED_FLOW_EVENT_STORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define WFES_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("wfes assertion failed");
`define WFES_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("wfes assertion failed");
`else
`define WFES_ASSERT(lbl, prop)
`define WFES_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### sv/wfes_pkg.sv
// types and codes shared by the windowed flow event store
// no dependencies
package wfes_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_STATS  = 3'd1,
    OP_SMB    = 3'd2,
    OP_BURST  = 3'd3,
    OP_EXPIRE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CFG_BURST_SPAN = 3'd0,
    CFG_BURST_MIN  = 3'd1,
    CFG_BIG_BYTES  = 3'd2,
    CFG_SMB_FIRST  = 3'd3,
    CFG_SMB_SECOND = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OREAD,
    ST_OCHK,
    ST_IREAD,
    ST_ICHK,
    ST_OEND,
    ST_XREAD,
    ST_XCHK,
    ST_DONE
  } state_e;

  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] stamp;
    logic [31:0] byte_len;
    logic [31:0] source_addr;
    logic [31:0] dest_addr;
    logic [15:0] source_port_num;
    logic [15:0] dest_port_num;
    logic [63:0] win_lo;
    logic [63:0] win_hi;
    logic [63:0] expire_cutoff;
  } in_beat_t;

  typedef struct packed {
    logic [12:0] hit_count;
    logic [47:0] byte_total;
    logic [13:0] distinct_addrs;
    logic [13:0] distinct_ports;
    logic [12:0] smb_dest_count;
    logic [12:0] burst_starts;
    logic [12:0] big_transfer_count;
    logic [12:0] evicted_count;
  } out_beat_t;

  typedef struct packed {
    logic [63:0] stamp;
    logic [31:0] bytes;
    logic [31:0] saddr;
    logic [31:0] daddr;
    logic [15:0] sport;
    logic [15:0] dport;
  } entry_t;

endpackage

### sv/wfes_ring.sv
// event ring storage, one write port and one registered read port
// depends on wfes_pkg
module wfes_ring #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  wfes_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output wfes_pkg::entry_t rdata_o
);

  wfes_pkg::entry_t mem [DEPTH];
  wfes_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/windowed_flow_event_store.sv
// Windowed flow event store. An add (op 0) stores one event, replacing the
// oldest when full, and gives no result. Queries (ops 1 to 3) walk the held
// events oldest first through one ring read port with registered data, and
// each in-window event (for op 2, only one to an SMB port) then rescans the
// earlier events (ops 1 and 2) or the later ones (op 3). Expiry (op 4) pops
// the oldest events while their stamp is below the cutoff. The input is
// stalled while a query or expiry runs and until its result is loaded into
// the output register; a finished result sits there until taken.
`include "windowed_flow_event_store_defines.svh"
module windowed_flow_event_store #(
  parameter int CAPACITY = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wfes_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wfes_pkg::out_beat_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  wfes_pkg::state_e state_q, state_d;

  logic [39:0] span_q;
  logic [12:0] min_q;
  logic [31:0] big_thr_q;
  logic [15:0] smb1_q, smb2_q;

  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] held_q, held_d;
  logic [CW-1:0] k_q, k_d, j_q, j_d;
  wfes_pkg::in_beat_t req_q, req_d;
  wfes_pkg::entry_t   ent_q, ent_d, rdata;

  logic f_sa_q, f_sa_d, f_da_q, f_da_d, f_sp_q, f_sp_d, f_dp_q, f_dp_d;
  logic stop_q, stop_d;
  logic [12:0] run_q, run_d;
  logic [12:0] hit_q, hit_d, smb_q, smb_d, bursts_q, bursts_d, big_q, big_d;
  logic [12:0] evict_q, evict_d;
  logic [47:0] total_q, total_d;
  logic [13:0] na_q, na_d, np_q, np_d;

  logic               out_valid_q, out_valid_d;
  wfes_pkg::out_beat_t out_q, out_d;

  logic          in_fire, we, re, rd_win, rd_smb, o_smb, out_load;
  logic [AW-1:0] waddr, raddr;
  logic [48:0]   sum;
  logic [63:0]   diff;

  assign in_fire     = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != wfes_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign rd_win = (rdata.stamp >= req_q.win_lo) && (rdata.stamp <= req_q.win_hi);
  assign rd_smb = (rdata.dport == smb1_q) || (rdata.dport == smb2_q);
  assign o_smb  = (ent_q.dport == smb1_q) || (ent_q.dport == smb2_q);
  assign sum    = {1'b0, total_q} + 49'(rdata.bytes);
  assign diff   = rdata.stamp - ent_q.stamp;
  assign out_load = (state_q == wfes_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  wfes_ring #(.DEPTH(CAPACITY), .AW(AW)) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({in_data_i.stamp, in_data_i.byte_len, in_data_i.source_addr,
               in_data_i.dest_addr, in_data_i.source_port_num,
               in_data_i.dest_port_num}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wfes_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_data_i.op)
            wfes_pkg::OP_STATS, wfes_pkg::OP_SMB, wfes_pkg::OP_BURST:
              state_d = wfes_pkg::ST_OREAD;
            wfes_pkg::OP_EXPIRE: state_d = wfes_pkg::ST_XREAD;
            default: state_d = wfes_pkg::ST_IDLE;
          endcase
        end
      end
      wfes_pkg::ST_OREAD:
        state_d = (k_q == held_q) ? wfes_pkg::ST_DONE : wfes_pkg::ST_OCHK;
      wfes_pkg::ST_OCHK: begin
        if (!rd_win || (req_q.op == wfes_pkg::OP_SMB && !rd_smb)) begin
          state_d = wfes_pkg::ST_OREAD;
        end else begin
          state_d = wfes_pkg::ST_IREAD;
        end
      end
      wfes_pkg::ST_IREAD: begin
        if ((req_q.op == wfes_pkg::OP_BURST) ? (j_q == held_q) : (j_q == k_q)) begin
          state_d = wfes_pkg::ST_OEND;
        end else begin
          state_d = wfes_pkg::ST_ICHK;
        end
      end
      wfes_pkg::ST_ICHK: state_d = wfes_pkg::ST_IREAD;
      wfes_pkg::ST_OEND: state_d = wfes_pkg::ST_OREAD;
      wfes_pkg::ST_XREAD:
        state_d = (held_q == '0) ? wfes_pkg::ST_DONE : wfes_pkg::ST_XCHK;
      wfes_pkg::ST_XCHK:
        state_d = (rdata.stamp < req_q.expire_cutoff) ? wfes_pkg::ST_XREAD
                                                      : wfes_pkg::ST_DONE;
      wfes_pkg::ST_DONE: if (out_load) state_d = wfes_pkg::ST_IDLE;
      default: state_d = wfes_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    oldest_d = oldest_q; held_d = held_q; k_d = k_q; j_d = j_q;
    req_d = req_q; ent_d = ent_q;
    f_sa_d = f_sa_q; f_da_d = f_da_q; f_sp_d = f_sp_q; f_dp_d = f_dp_q;
    stop_d = stop_q; run_d = run_q;
    hit_d = hit_q; smb_d = smb_q; bursts_d = bursts_q; big_d = big_q;
    evict_d = evict_q; total_d = total_q; na_d = na_q; np_d = np_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we = 1'b0; waddr = oldest_q; re = 1'b0; raddr = oldest_q;
    case (state_q)
      wfes_pkg::ST_IDLE: begin
        if (in_fire) begin
          req_d = in_data_i;
          k_d = '0; hit_d = '0; total_d = '0; na_d = '0; np_d = '0;
          smb_d = '0; bursts_d = '0; big_d = '0; evict_d = '0;
          if (in_data_i.op == wfes_pkg::OP_ADD) begin
            we = 1'b1;
            if (held_q < CW'(CAPACITY)) begin
              waddr  = slot_of(oldest_q, held_q);
              held_d = held_q + 1'b1;
            end else begin
              oldest_d = (oldest_q == AW'(CAPACITY - 1)) ? '0 : oldest_q + 1'b1;
            end
          end
        end
      end
      wfes_pkg::ST_OREAD: begin
        re = 1'b1;
        raddr = slot_of(oldest_q, k_q);
      end
      wfes_pkg::ST_OCHK: begin
        ent_d = rdata;
        f_sa_d = 1'b0; f_da_d = 1'b0; f_sp_d = 1'b0; f_dp_d = 1'b0;
        stop_d = 1'b0; run_d = 13'd1;
        j_d = (req_q.op == wfes_pkg::OP_BURST) ? k_q + 1'b1 : '0;
        if (!rd_win || (req_q.op == wfes_pkg::OP_SMB && !rd_smb)) begin
          k_d = k_q + 1'b1;
        end else begin
          hit_d   = hit_q + 1'b1;
          total_d = sum[48] ? wfes_pkg::SAT48 : sum[47:0];
          if (rdata.bytes > big_thr_q) big_d = big_q + 1'b1;
        end
      end
      wfes_pkg::ST_IREAD: begin
        re = 1'b1;
        raddr = slot_of(oldest_q, j_q);
      end
      wfes_pkg::ST_ICHK: begin
        j_d = j_q + 1'b1;
        if (rd_win) begin
          case (req_q.op)
            wfes_pkg::OP_STATS: begin
              if (rdata.saddr == ent_q.saddr || rdata.daddr == ent_q.saddr) f_sa_d = 1'b1;
              if (rdata.saddr == ent_q.daddr || rdata.daddr == ent_q.daddr) f_da_d = 1'b1;
              if (rdata.sport == ent_q.sport || rdata.dport == ent_q.sport) f_sp_d = 1'b1;
              if (rdata.sport == ent_q.dport || rdata.dport == ent_q.dport) f_dp_d = 1'b1;
            end
            wfes_pkg::OP_SMB: begin
              if (rd_smb && rdata.daddr == ent_q.daddr) f_da_d = 1'b1;
            end
            wfes_pkg::OP_BURST: begin
              // run ends at the first in-window event outside the span
              if (!stop_q) begin
                if (diff < {24'd0, span_q}) run_d = run_q + 1'b1;
                else stop_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      wfes_pkg::ST_OEND: begin
        k_d = k_q + 1'b1;
        case (req_q.op)
          wfes_pkg::OP_STATS: begin
            na_d = na_q + 14'(!f_sa_q) + 14'((ent_q.daddr != ent_q.saddr) && !f_da_q);
            np_d = np_q + 14'(!f_sp_q) + 14'((ent_q.dport != ent_q.sport) && !f_dp_q);
          end
          wfes_pkg::OP_SMB: if (o_smb && !f_da_q) smb_d = smb_q + 1'b1;
          wfes_pkg::OP_BURST: if (run_q > min_q) bursts_d = bursts_q + 1'b1;
          default: ;
        endcase
      end
      wfes_pkg::ST_XREAD: begin
        re = 1'b1;
        raddr = oldest_q;
      end
      wfes_pkg::ST_XCHK: begin
        if (rdata.stamp < req_q.expire_cutoff) begin
          oldest_d = (oldest_q == AW'(CAPACITY - 1)) ? '0 : oldest_q + 1'b1;
          held_d   = held_q - 1'b1;
          evict_d  = evict_q + 1'b1;
        end
      end
      wfes_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_d = '0;
          case (req_q.op)
            wfes_pkg::OP_STATS: begin
              out_d.hit_count      = hit_q;
              out_d.byte_total     = total_q;
              out_d.distinct_addrs = na_q;
              out_d.distinct_ports = np_q;
            end
            wfes_pkg::OP_SMB: out_d.smb_dest_count = smb_q;
            wfes_pkg::OP_BURST: begin
              out_d.burst_starts       = bursts_q;
              out_d.big_transfer_count = big_q;
            end
            default: out_d.evicted_count = evict_q;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wfes_pkg::ST_IDLE;
      oldest_q    <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
      span_q      <= 40'd5000000000;
      min_q       <= 13'd10;
      big_thr_q   <= 32'd10485760;
      smb1_q      <= 16'd139;
      smb2_q      <= 16'd445;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          wfes_pkg::CFG_BURST_SPAN: span_q    <= cfg_data_i[39:0];
          wfes_pkg::CFG_BURST_MIN:  min_q     <= cfg_data_i[12:0];
          wfes_pkg::CFG_BIG_BYTES:  big_thr_q <= cfg_data_i[31:0];
          wfes_pkg::CFG_SMB_FIRST:  smb1_q    <= cfg_data_i[15:0];
          wfes_pkg::CFG_SMB_SECOND: smb2_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d; j_q <= j_d; req_q <= req_d; ent_q <= ent_d;
    f_sa_q <= f_sa_d; f_da_q <= f_da_d; f_sp_q <= f_sp_d; f_dp_q <= f_dp_d;
    stop_q <= stop_d; run_q <= run_d;
    hit_q <= hit_d; smb_q <= smb_d; bursts_q <= bursts_d; big_q <= big_d;
    evict_q <= evict_d; total_q <= total_d; na_q <= na_d; np_q <= np_d;
    out_q <= out_d;
  end

  `WFES_ASSERT(a_done_loads_out, out_load |=> out_valid_q && state_q == wfes_pkg::ST_IDLE)
  `WFES_ASSERT(a_expire_pops, state_q == wfes_pkg::ST_XCHK && rdata.stamp < req_q.expire_cutoff |=> held_q == $past(held_q) - 1'b1)
  `WFES_ASSERT(a_full_add_keeps, in_fire && in_data_i.op == wfes_pkg::OP_ADD && held_q == CW'(CAPACITY) |=> held_q == CW'(CAPACITY))
  `WFES_ASSERT_ALWAYS(a_held_bound, held_q <= CW'(CAPACITY))

endmodule
